// ----- design/text_console_engine_defines.svh -----
// Assertion macros used by the text console engine top level.
// Depends on nothing; each user provides clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_ENGINE_DEFINES_SVH
`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define TCE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("text console engine assertion failed");
// Checked property that also holds during reset.
`define TCE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("text console engine assertion failed");
`else
`define TCE_ASSERT(lbl, prop)
`define TCE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- design/tce_pkg.sv -----
// Shared types, constants and the screen color table of the text console engine.
// Depends on nothing; used by tce_mem and text_console_engine.
package tce_pkg;

  // Default geometry.
  localparam int TCE_COLS        = 80;
  localparam int TCE_ROWS        = 25;
  localparam int TCE_SCREENS     = 10;
  localparam int TCE_HEADER_ROWS = 6;

  // Character codes.
  localparam logic [7:0]  CH_BLANK    = 8'h20;
  localparam logic [7:0]  KEY_NEWLINE = 8'h0A;
  localparam logic [7:0]  KEY_BACKSP  = 8'h0E;
  localparam logic [7:0]  RESET_COLOR = 8'h0B;
  localparam logic [4:0]  SCREEN_NEG  = 5'd9;

  // Requested operation.
  typedef enum logic [2:0] {
    A_PUT    = 3'd0,
    A_DEL    = 3'd1,
    A_SWITCH = 3'd2,
    A_COLOR  = 3'd3,
    A_READ   = 3'd4
  } action_e;

  // Read enable and write enables of the two stores.
  typedef struct packed {
    logic rd;
    logic disp_we;
    logic char_we;
  } mem_ctl_t;

  // Fixed attribute of each screen.
  function automatic logic [7:0] tce_color(input logic [3:0] n);
    logic [7:0] c;
    case (n)
      4'd0:    c = 8'h0B;
      4'd1:    c = 8'h09;
      4'd2:    c = 8'h02;
      4'd3:    c = 8'h0D;
      4'd4:    c = 8'h04;
      4'd5:    c = 8'h0F;
      4'd6:    c = 8'h07;
      4'd7:    c = 8'h0E;
      4'd8:    c = 8'h4E;
      4'd9:    c = 8'hF0;
      default: c = 8'h0B;
    endcase
    return c;
  endfunction

endpackage

// ----- design/tce_mem.sv -----
// Display store and character store of the text console engine.
// Both are synchronous memories with registered read data; uses tce_pkg.
module tce_mem #(
  parameter int DISP_DEPTH = 2000,
  parameter int CHAR_DEPTH = 20000
) (
  input  logic                            clk_i,
  input  tce_pkg::mem_ctl_t               ctl_i,
  input  logic [$clog2(DISP_DEPTH)-1:0]   disp_raddr_i,
  input  logic [$clog2(DISP_DEPTH)-1:0]   disp_waddr_i,
  input  logic [15:0]                     disp_wdata_i,
  input  logic [$clog2(CHAR_DEPTH)-1:0]   char_raddr_i,
  input  logic [$clog2(CHAR_DEPTH)-1:0]   char_waddr_i,
  input  logic [7:0]                      char_wdata_i,
  output logic [15:0]                     disp_rdata_o,
  output logic [7:0]                      char_rdata_o
);
  import tce_pkg::*;

  logic [15:0] disp_mem [DISP_DEPTH];
  logic [7:0]  char_mem [CHAR_DEPTH];

  // Display store port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.disp_we) begin
      disp_mem[disp_waddr_i] <= disp_wdata_i;
    end
    if (ctl_i.rd) begin
      disp_rdata_o <= disp_mem[disp_raddr_i];
    end
  end

  // Character store port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.char_we) begin
      char_mem[char_waddr_i] <= char_wdata_i;
    end
    if (ctl_i.rd) begin
      char_rdata_o <= char_mem[char_raddr_i];
    end
  end

endmodule

// ----- design/text_console_engine.sv -----
// Top level of the multi-screen text console engine: command sequencer and cursors.
// Depends on tce_pkg, tce_mem and text_console_engine_defines.svh.
//
// Usage: a command is transferred at a rising edge where start_i is high and
// busy_o is low. Exactly one result follows, shown for one cycle with done_o
// high; the receiver takes it then and cannot delay it.
// Work per command, done by the sequencer walking the stores one cell per cycle:
//   set_color, unknown action, ignored switch or delete: the result alone.
//   read_cell: one display store read, none when the index lies past the last cell.
//   newline: steps through the row starts, plus the scroll below when it runs off.
//   put_char: moves the cells from the cursor on up one and writes the character,
//     plus a scroll of the rows below the header when the cursor runs off the end.
//   delete: moves the cells behind the cursor down one and blanks the last cell;
//     a backspace first moves the cursor back one.
//   screen switch: copies every cell of the new screen into the display store.
// The worst case at 80 x 25 is the screen switch; busy_o stays high until done_o.
// After reset a clearing pass writes both stores, with busy_o high.
module text_console_engine #(
  parameter int COLS        = tce_pkg::TCE_COLS,
  parameter int ROWS        = tce_pkg::TCE_ROWS,
  parameter int SCREENS     = tce_pkg::TCE_SCREENS,
  parameter int HEADER_ROWS = tce_pkg::TCE_HEADER_ROWS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        action_i,
  input  logic [7:0]        char_code_i,
  input  logic signed [4:0] screen_number_i,
  input  logic [7:0]        new_color_i,
  input  logic [10:0]       cell_index_i,
  output logic              done_o,
  output logic [15:0]       cell_data_o,
  output logic [10:0]       cursor_pos_o,
  output logic [3:0]        active_screen_o
);
  import tce_pkg::*;

  localparam int CELLS     = COLS * ROWS;
  localparam int CHARS     = SCREENS * CELLS;
  localparam int AW        = $clog2(CELLS);
  localparam int CAW       = $clog2(CHARS);
  localparam int SW        = (SCREENS > 1) ? $clog2(SCREENS) : 1;
  localparam int RW        = $clog2(CELLS + COLS + 1);
  localparam int HDR_CELLS = HEADER_ROWS * COLS;
  localparam int LAST_ROW  = (ROWS - 1) * COLS;
  localparam int SCR_ROWS  = ROWS - HEADER_ROWS - 1;
  localparam int SCR_FIRST = HDR_CELLS + COLS;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_ROWS  = 9'b000000100,
    S_SWEEP = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_PUT   = 9'b000100000,
    S_FILL  = 9'b001000000,
    S_READ  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  typedef enum logic [1:0] {
    J_INS    = 2'd0,
    J_DEL    = 2'd1,
    J_SCROLL = 2'd2,
    J_SWITCH = 2'd3
  } job_e;

  state_e         state_q, state_d;
  job_e           job_q, job_d;
  logic [AW-1:0]  r_q, r_d, r_end_q, r_end_d, rdi_q, cur_q, cur_d;
  logic           up_q, up_d, wr_pend_q;
  logic [CAW-1:0] base_q, base_d, clr_q, clr_d;
  logic [RW-1:0]  rs_q, rs_d, nc;
  logic [7:0]     ch_q, ch_d, color_q, color_d;
  logic [SW-1:0]  shown_q, shown_d;
  logic [AW-1:0]  cursors_q [SCREENS];
  logic [15:0]    cell_data_q, cell_data_d;
  logic           cwe, go_scroll;
  logic [AW-1:0]  cwval, cur_rd, c2, widx;
  logic [4:0]     sn;

  mem_ctl_t       ctl;
  logic [AW-1:0]  disp_raddr, disp_waddr;
  logic [CAW-1:0] char_raddr, char_waddr;
  logic [15:0]    disp_wdata, disp_rdata;
  logic [7:0]     char_wdata, char_rdata;

  assign cur_rd = cursors_q[shown_q];
  assign sn     = screen_number_i[4] ? SCREEN_NEG : {1'b0, screen_number_i[3:0]};

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    r_d         = r_q;
    r_end_d     = r_end_q;
    up_d        = up_q;
    base_d      = base_q;
    clr_d       = clr_q;
    rs_d        = rs_q;
    ch_d        = ch_q;
    color_d     = color_q;
    shown_d     = shown_q;
    cur_d       = cur_q;
    cell_data_d = cell_data_q;
    cwe         = 1'b0;
    cwval       = cur_q;
    go_scroll   = 1'b0;
    c2          = cur_rd;
    nc          = '0;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + CAW'(1);
        if (clr_q == CAW'(CHARS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          cell_data_d = '0;
          base_d      = CAW'(shown_q) * CAW'(CELLS);
          ch_d        = char_code_i;
          cur_d       = cur_rd;
          state_d     = S_DONE;
          case (action_i)
            A_PUT: begin
              if (char_code_i == KEY_NEWLINE) begin
                rs_d    = '0;
                state_d = S_ROWS;
              end else if (32'(cur_rd) < CELLS - 1) begin
                job_d   = J_INS;
                r_d     = AW'(CELLS - 2);
                r_end_d = cur_rd;
                up_d    = 1'b0;
                state_d = S_SWEEP;
              end else begin
                state_d = S_PUT;
              end
            end
            A_DEL: begin
              if (!(32'(cur_rd) == HDR_CELLS ||
                    (char_code_i == KEY_BACKSP && cur_rd == '0))) begin
                c2    = (char_code_i == KEY_BACKSP) ? cur_rd - AW'(1) : cur_rd;
                cwe   = 1'b1;
                cwval = c2;
                job_d = J_DEL;
                r_end_d = AW'(CELLS - 1);
                up_d  = 1'b1;
                if (32'(c2) < CELLS - 1) begin
                  r_d     = c2 + AW'(1);
                  state_d = S_SWEEP;
                end else begin
                  r_d     = AW'(CELLS - 1);
                  state_d = S_FILL;
                end
              end
            end
            A_SWITCH: begin
              if (32'(sn) < SCREENS && 32'(sn) != 32'(shown_q)) begin
                shown_d = SW'(sn);
                color_d = tce_color(sn[3:0]);
                base_d  = CAW'(sn) * CAW'(CELLS);
                job_d   = J_SWITCH;
                r_d     = '0;
                r_end_d = AW'(CELLS - 1);
                up_d    = 1'b1;
                state_d = S_SWEEP;
              end
            end
            A_COLOR: begin
              color_d = new_color_i;
            end
            A_READ: begin
              if (32'(cell_index_i) < CELLS) begin
                state_d = S_READ;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_ROWS: begin
        // Walk row starts until the one past the cursor.
        if (rs_q + RW'(COLS) <= RW'(cur_q)) begin
          rs_d = rs_q + RW'(COLS);
        end else begin
          nc = rs_q + RW'(COLS);
          if (32'(nc) >= CELLS) begin
            go_scroll = 1'b1;
          end else begin
            cwe     = 1'b1;
            cwval   = AW'(nc);
            state_d = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        if (r_q == r_end_q) begin
          state_d = S_DRAIN;
        end else begin
          r_d = up_q ? r_q + AW'(1) : r_q - AW'(1);
        end
      end
      S_DRAIN: begin
        case (job_q)
          J_INS: begin
            state_d = S_PUT;
          end
          J_DEL: begin
            r_d     = AW'(CELLS - 1);
            r_end_d = AW'(CELLS - 1);
            state_d = S_FILL;
          end
          J_SCROLL: begin
            r_d     = AW'(LAST_ROW);
            r_end_d = AW'(CELLS - 1);
            state_d = S_FILL;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_PUT: begin
        nc = RW'(cur_q) + RW'(1);
        if (32'(nc) >= CELLS) begin
          go_scroll = 1'b1;
        end else begin
          cwe     = 1'b1;
          cwval   = AW'(nc);
          state_d = S_DONE;
        end
      end
      S_FILL: begin
        if (r_q == r_end_q) begin
          state_d = S_DONE;
        end else begin
          r_d = r_q + AW'(1);
        end
      end
      S_READ: begin
        cell_data_d = disp_rdata;
        state_d     = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Scroll the area below the header and blank the last row.
    if (go_scroll) begin
      cwe     = 1'b1;
      cwval   = AW'(LAST_ROW);
      job_d   = J_SCROLL;
      up_d    = 1'b1;
      r_end_d = AW'(CELLS - 1);
      if (SCR_ROWS > 0) begin
        r_d     = AW'(SCR_FIRST);
        state_d = S_SWEEP;
      end else begin
        r_d     = AW'(LAST_ROW);
        state_d = S_FILL;
      end
    end
  end

  // Write index of the pending sweep transfer.
  always_comb begin
    case (job_q)
      J_INS:    widx = rdi_q + AW'(1);
      J_DEL:    widx = rdi_q - AW'(1);
      J_SCROLL: widx = rdi_q - AW'(COLS);
      default:  widx = rdi_q;
    endcase
  end

  // Store access selection.
  always_comb begin
    ctl.rd     = (state_q == S_SWEEP) || (state_q == S_IDLE);
    ctl.disp_we = 1'b0;
    ctl.char_we = 1'b0;
    disp_raddr = (state_q == S_IDLE) ? AW'(cell_index_i) : r_q;
    char_raddr = base_q + CAW'(r_q);
    disp_waddr = widx;
    char_waddr = base_q + CAW'(widx);
    disp_wdata = (job_q == J_SWITCH) ? {color_q, char_rdata} : disp_rdata;
    char_wdata = char_rdata;
    if (state_q == S_CLEAR) begin
      ctl.char_we = 1'b1;
      ctl.disp_we = 32'(clr_q) < CELLS;
      char_waddr  = clr_q;
      disp_waddr  = AW'(clr_q);
      char_wdata  = CH_BLANK;
      disp_wdata  = {RESET_COLOR, CH_BLANK};
    end else if (state_q == S_PUT) begin
      ctl.char_we = 1'b1;
      ctl.disp_we = 1'b1;
      char_waddr  = base_q + CAW'(cur_q);
      disp_waddr  = cur_q;
      char_wdata  = ch_q;
      disp_wdata  = {color_q, ch_q};
    end else if (state_q == S_FILL) begin
      ctl.char_we = 1'b1;
      ctl.disp_we = 1'b1;
      char_waddr  = base_q + CAW'(r_q);
      disp_waddr  = r_q;
      char_wdata  = CH_BLANK;
      disp_wdata  = {color_q, CH_BLANK};
    end else if (wr_pend_q) begin
      ctl.disp_we = 1'b1;
      ctl.char_we = (job_q != J_SWITCH);
    end
  end

  tce_mem #(
    .DISP_DEPTH(CELLS),
    .CHAR_DEPTH(CHARS)
  ) u_mem (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .disp_raddr_i (disp_raddr),
    .disp_waddr_i (disp_waddr),
    .disp_wdata_i (disp_wdata),
    .char_raddr_i (char_raddr),
    .char_waddr_i (char_waddr),
    .char_wdata_i (char_wdata),
    .disp_rdata_o (disp_rdata),
    .char_rdata_o (char_rdata)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      wr_pend_q <= 1'b0;
      shown_q   <= '0;
      color_q   <= RESET_COLOR;
      for (int i = 0; i < SCREENS; i++) begin
        cursors_q[i] <= AW'(HDR_CELLS);
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wr_pend_q <= (state_q == S_SWEEP);
      shown_q   <= shown_d;
      color_q   <= color_d;
      if (cwe) begin
        cursors_q[shown_q] <= cwval;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    job_q       <= job_d;
    r_q         <= r_d;
    r_end_q     <= r_end_d;
    up_q        <= up_d;
    rdi_q       <= r_q;
    base_q      <= base_d;
    rs_q        <= rs_d;
    ch_q        <= ch_d;
    cur_q       <= cur_d;
    cell_data_q <= cell_data_d;
  end

  // Result ports.
  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign cell_data_o     = cell_data_q;
  assign cursor_pos_o    = 11'(cur_rd);
  assign active_screen_o = 4'(shown_q);

`include "text_console_engine_defines.svh"

  `TCE_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o)
  `TCE_ASSERT(a_done_single, done_o |=> !done_o)
  `TCE_ASSERT(a_wr_in_sweep, wr_pend_q |-> (state_q == S_SWEEP || state_q == S_DRAIN))
  `TCE_ASSERT(a_cursor_range, 32'(cur_rd) < CELLS)
  `TCE_ASSERT_ALWAYS(a_shown_range, 32'(shown_q) < SCREENS)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for text_console_engine: directed and random commands.
// Depends on tce_pkg and the text_console_engine RTL; keeps its own console model.
`timescale 1ns / 1ps

module tb_top;
  import tce_pkg::*;

  localparam int NCOLS   = TCE_COLS;
  localparam int NCELLS  = TCE_COLS * TCE_ROWS;
  localparam int NSCR    = TCE_SCREENS;
  localparam int HDR_END = TCE_HEADER_ROWS * TCE_COLS;
  localparam int LAST_ROW = (TCE_ROWS - 1) * TCE_COLS;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [15:0] cell_val;
    logic [10:0] cursor;
    logic [3:0]  screen;
  } console_out_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic              busy_o;
  logic [2:0]        action_i = '0;
  logic [7:0]        char_code_i = '0;
  logic signed [4:0] screen_number_i = '0;
  logic [7:0]        new_color_i = '0;
  logic [10:0]       cell_index_i = '0;
  logic              done_o;
  logic [15:0]       cell_data_o;
  logic [10:0]       cursor_pos_o;
  logic [3:0]        active_screen_o;

  // Console model state.
  logic [15:0] shown_cells[NCELLS];
  logic [7:0]  screen_text[NSCR][NCELLS];
  int          text_cursor[NSCR];
  int          shown_idx;
  logic [7:0]  pen_color;

  console_out_t pending_results[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           sender_idle_pct = 0;

  text_console_engine dut (.*);

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] screen_attr(input int n);
    logic [7:0] attrs[10];
    attrs = '{8'h0B, 8'h09, 8'h02, 8'h0D, 8'h04, 8'h0F, 8'h07, 8'h0E, 8'h4E, 8'hF0};
    return (n < 10) ? attrs[n] : RESET_COLOR;
  endfunction

  function automatic void clear_console();
    for (int i = 0; i < NCELLS; i++) begin
      shown_cells[i] = {RESET_COLOR, CH_BLANK};
      for (int s = 0; s < NSCR; s++) screen_text[s][i] = CH_BLANK;
    end
    for (int s = 0; s < NSCR; s++) text_cursor[s] = HDR_END;
    shown_idx = 0;
    pen_color = RESET_COLOR;
  endfunction

  // Rows below the header move up one, and the last row blanks.
  function automatic void scroll_screen();
    if (TCE_HEADER_ROWS + 1 < TCE_ROWS) begin
      for (int i = HDR_END; i < LAST_ROW; i++) begin
        screen_text[shown_idx][i] = screen_text[shown_idx][i + NCOLS];
        shown_cells[i] = shown_cells[i + NCOLS];
      end
    end
    for (int i = LAST_ROW; i < NCELLS; i++) begin
      screen_text[shown_idx][i] = CH_BLANK;
      shown_cells[i] = {pen_color, CH_BLANK};
    end
  endfunction

  // Applies one command to the model and returns the result it produces.
  function automatic console_out_t apply_command(input logic [2:0] act, input logic [7:0] ch,
                                                 input logic [4:0] scr, input logic [7:0] col,
                                                 input logic [10:0] idx);
    console_out_t res;
    int cur;
    int n;
    res.cell_val = '0;
    cur = text_cursor[shown_idx];
    case (act)
      A_PUT: begin
        if (ch == KEY_NEWLINE) begin
          cur = cur + NCOLS;
          cur = cur - (cur % NCOLS);
        end else if (cur < NCELLS) begin
          for (int i = NCELLS - 1; i > cur; i--) begin
            screen_text[shown_idx][i] = screen_text[shown_idx][i - 1];
            shown_cells[i] = shown_cells[i - 1];
          end
          screen_text[shown_idx][cur] = ch;
          shown_cells[cur] = {pen_color, ch};
          cur++;
        end
        if (cur >= NCELLS) begin
          scroll_screen();
          cur = LAST_ROW;
        end
        text_cursor[shown_idx] = cur;
      end
      A_DEL: begin
        // Nothing happens at the header boundary or on backspace at cell zero.
        if (cur != HDR_END && !(ch == KEY_BACKSP && cur == 0)) begin
          if (ch == KEY_BACKSP) cur--;
          if (cur < NCELLS) begin
            for (int i = cur; i < NCELLS - 1; i++) begin
              screen_text[shown_idx][i] = screen_text[shown_idx][i + 1];
              shown_cells[i] = shown_cells[i + 1];
            end
            screen_text[shown_idx][NCELLS - 1] = CH_BLANK;
            shown_cells[NCELLS - 1] = {pen_color, CH_BLANK};
          end
          text_cursor[shown_idx] = cur;
        end
      end
      A_SWITCH: begin
        n = scr[4] ? int'(SCREEN_NEG) : int'(scr);
        if (n < NSCR && n != shown_idx) begin
          shown_idx = n;
          pen_color = screen_attr(n);
          for (int i = 0; i < NCELLS; i++) shown_cells[i] = {pen_color, screen_text[n][i]};
        end
      end
      A_COLOR: pen_color = col;
      A_READ: if (idx < NCELLS) res.cell_val = shown_cells[idx];
      default: ;
    endcase
    res.cursor = 11'(text_cursor[shown_idx]);
    res.screen = 4'(shown_idx);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Each result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    console_out_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", cell_data_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (cell_data_o !== want.cell_val)
          report_mismatch("cell_data", cell_data_o, want.cell_val);
        if (cursor_pos_o !== want.cursor)
          report_mismatch("cursor_pos", cursor_pos_o, want.cursor);
        if (active_screen_o !== want.screen)
          report_mismatch("active_screen", active_screen_o, want.screen);
      end
    end
  end

  // Sends one command and predicts its result once the transfer happens.
  task automatic send_command(input logic [2:0] act, input logic [7:0] ch = 8'h41,
                              input logic [4:0] scr = '0, input logic [7:0] col = '0,
                              input logic [10:0] idx = '0);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(20, 1);
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i = act;
    char_code_i = ch;
    screen_number_i = scr;
    new_color_i = col;
    cell_index_i = idx;
    start_i = 1'b1;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_command(act, ch, scr, col, idx));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_insert_and_read();
    send_command(A_PUT, 8'h00);
    send_command(A_PUT, 8'hFF);
    send_command(A_COLOR, .col(8'hFF));
    send_command(A_PUT, 8'h41);
    send_command(A_COLOR, .col(8'h00));
    send_command(A_READ, .idx(11'd480));
    send_command(A_READ, .idx(11'd482));
    send_command(A_READ, .idx(11'd0));
    send_command(A_READ, .idx(11'd1999));
    send_command(A_READ, .idx(11'd2000));
    send_command(A_READ, .idx(11'h7FF));
    send_command(3'd5);
    send_command(3'd6);
    send_command(3'd7);
  endtask

  task automatic test_delete();
    send_command(A_DEL, KEY_BACKSP);
    send_command(A_DEL, 8'h00);
    send_command(A_DEL, 8'hFF);
    send_command(A_READ, .idx(11'd480));
    send_command(A_READ, .idx(11'd1999));
  endtask

  // Newlines run the cursor off the end so the screen scrolls.
  task automatic test_scroll();
    send_command(A_PUT, 8'h5A);
    for (int i = 0; i < TCE_ROWS - TCE_HEADER_ROWS; i++) send_command(A_PUT, KEY_NEWLINE);
    send_command(A_READ, .idx(11'd480));
    send_command(A_READ, .idx(11'd1920));
    send_command(A_DEL, 8'h00);
  endtask

  task automatic test_switch();
    send_command(A_SWITCH, .scr(5'd0));
    send_command(A_SWITCH, .scr(5'd10));
    send_command(A_SWITCH, .scr(5'd15));
    send_command(A_SWITCH, .scr(5'h1F));
    send_command(A_READ, .idx(11'd1920));
    send_command(A_SWITCH, .scr(5'h10));
    send_command(A_SWITCH, .scr(5'd0));
    send_command(A_READ, .idx(11'd480));
  endtask

  task automatic test_random(input int count);
    int pick;
    logic [2:0] act;
    logic [7:0] ch;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      ch = 8'($urandom);
      if (pick < 40) begin
        act = A_PUT;
        if ($urandom_range(99) < 20) ch = KEY_NEWLINE;
      end else if (pick < 55) begin
        act = A_DEL;
        if ($urandom_range(1)) ch = KEY_BACKSP;
      end else if (pick < 63) act = A_SWITCH;
      else if (pick < 70) act = A_COLOR;
      else if (pick < 95) act = A_READ;
      else act = 3'($urandom_range(7, 5));
      send_command(act, ch, 5'($urandom), 8'($urandom), 11'($urandom));
    end
  endtask

  initial begin
    clear_console();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    sender_idle_pct = 35;
    test_insert_and_read();
    test_delete();
    test_scroll();
    test_switch();
    test_random(30);
    wait_drained();
    sender_idle_pct = 70;
    test_random(30);
    sender_idle_pct = 0;
    test_random(30);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
